// File: rtl/core/pll_pkg.sv
// Shared types and codes for the positional linked list.
package pll_pkg;

  typedef enum logic [2:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_INS_POS  = 3'd2,
    FN_DEL_HEAD = 3'd3,
    FN_DEL_TAIL = 3'd4,
    FN_DEL_POS  = 3'd5,
    FN_DUMP     = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KD_NONE,
    KD_INS,
    KD_DEL,
    KD_DUMP
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_INS_LINK,
    S_DEL_WR,
    S_DUMP,
    S_EMIT
  } state_t;

  // take pops a node index, give pushes the index being freed
  typedef struct packed {
    logic take;
    logic give;
  } alloc_op_t;

endpackage

// File: rtl/core/pll_if.sv
// Request and result channel interfaces.
interface pll_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] value;
  logic [6:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface pll_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic [6:0]         entry_count;
  logic               last;

  modport source (output valid, status, element, entry_count, last, input ready);
  modport sink   (input valid, status, element, entry_count, last, output ready);
endinterface

// File: rtl/core/pll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/pll_alloc.sv
// Free node index allocator: a stack of released indices plus a fresh-index counter.
module pll_alloc #(
  parameter int CAPACITY = 16,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  pll_pkg::alloc_op_t op,
  input  logic [IW-1:0]     free_idx,
  output logic [IW-1:0]     alloc_idx
);

  logic [CW-1:0] stk_cnt;
  logic [CW-1:0] fresh;
  logic [CW-1:0] stk_top;
  logic [IW-1:0] stk_rd;

  assign stk_top = (stk_cnt != '0) ? stk_cnt - CW'(1) : '0;

  pll_ram #(
    .WIDTH (IW),
    .DEPTH (CAPACITY)
  ) u_stack (
    .clk   (clk),
    .we    (op.give),
    .waddr (stk_cnt[IW-1:0]),
    .wdata (free_idx),
    .raddr (stk_top[IW-1:0]),
    .rdata (stk_rd)
  );

  // stack read data is registered, so it settles in the cycle after the count moves
  assign alloc_idx = (stk_cnt != '0) ? stk_rd : fresh[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stk_cnt <= '0;
      fresh   <= '0;
    end else if (op.take) begin
      if (stk_cnt != '0) begin
        stk_cnt <= stk_cnt - CW'(1);
      end else begin
        fresh <= fresh + CW'(1);
      end
    end else if (op.give) begin
      stk_cnt <= stk_cnt + CW'(1);
    end
  end

endmodule

// File: rtl/core/positional_linked_list.sv
// Positional singly linked list over a node RAM, with a free index allocator.
// One request at a time. Status-only results go straight to emit; a head insert writes
// its node in load; a head delete passes load and walk; insert/delete at 1-based position
// p >= 2 (tail insert: p = count + 1) walks to the predecessor, one node RAM read per step,
// then rewrites its link. Dump: one element per cycle; a held result stalls it all.
// Synchronous reset clears count, head and allocator; node RAMs need no clear.
module positional_linked_list #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  pll_req_if.sink   req,
  pll_rsp_if.source rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = 32 + IW;

  pll_pkg::state_t  state, state_next;
  pll_pkg::kind_t   kind;
  pll_pkg::status_t res_st;

  logic [CW-1:0]      used;
  logic [CW-1:0]      steps;
  logic [IW-1:0]      head, cur, nidx, plink;
  logic signed [31:0] val_q, pval;
  logic               at_head;

  logic               out_valid, out_last, out_free, out_load;
  pll_pkg::status_t   out_st;
  logic signed [31:0] out_el;
  logic [6:0]         out_cnt;

  logic               n_we;
  logic [IW-1:0]      n_waddr, n_raddr;
  logic [NW-1:0]      n_wdata, node_rd;
  logic signed [31:0] rd_val;
  logic [IW-1:0]      rd_link;

  pll_pkg::alloc_op_t aop;
  logic [IW-1:0]      free_idx, alloc_idx;

  pll_pkg::status_t   dec_st;
  pll_pkg::kind_t     dec_kind;
  logic [CW-1:0]      dec_steps;
  logic               dec_head;
  logic [7:0]         pos8, used8;
  logic               full, accept;

  pll_ram #(
    .WIDTH (NW),
    .DEPTH (CAPACITY)
  ) u_nodes (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (node_rd)
  );

  pll_alloc #(
    .CAPACITY (CAPACITY)
  ) u_alloc (
    .clk       (clk),
    .rst       (rst),
    .op        (aop),
    .free_idx  (free_idx),
    .alloc_idx (alloc_idx)
  );

  assign rd_val  = node_rd[NW-1:IW];
  assign rd_link = node_rd[IW-1:0];

  assign req.ready = (state == pll_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign free_idx  = (state == pll_pkg::S_DEL_WR) ? plink : cur;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_st;
  assign rsp.element     = out_el;
  assign rsp.entry_count = out_cnt;
  assign rsp.last        = out_last;

  // request decode: status checks and the walk length to the predecessor
  always_comb begin
    pos8      = {1'b0, req.position};
    used8     = 8'(used);
    full      = (used == CW'(CAPACITY));
    dec_st    = pll_pkg::ST_OK;
    dec_kind  = pll_pkg::KD_NONE;
    dec_steps = '0;
    dec_head  = 1'b0;
    unique case (pll_pkg::func_t'(req.func))
      pll_pkg::FN_INS_HEAD: begin
        if (full) begin
          dec_st = pll_pkg::ST_FULL;
        end else begin
          dec_kind = pll_pkg::KD_INS;
          dec_head = 1'b1;
        end
      end
      pll_pkg::FN_INS_TAIL: begin
        if (full) begin
          dec_st = pll_pkg::ST_FULL;
        end else begin
          dec_kind  = pll_pkg::KD_INS;
          dec_head  = (used8 == 8'd0);
          dec_steps = CW'(used8 - 8'd1);
        end
      end
      pll_pkg::FN_INS_POS: begin
        if (pos8 == 8'd0 || pos8 > used8 + 8'd1) begin
          dec_st = pll_pkg::ST_BADPOS;
        end else if (full) begin
          dec_st = pll_pkg::ST_FULL;
        end else begin
          dec_kind  = pll_pkg::KD_INS;
          dec_head  = (pos8 == 8'd1);
          dec_steps = CW'(pos8 - 8'd2);
        end
      end
      pll_pkg::FN_DEL_HEAD: begin
        if (used8 == 8'd0) begin
          dec_st = pll_pkg::ST_EMPTY;
        end else begin
          dec_kind = pll_pkg::KD_DEL;
          dec_head = 1'b1;
        end
      end
      pll_pkg::FN_DEL_TAIL: begin
        if (used8 == 8'd0) begin
          dec_st = pll_pkg::ST_EMPTY;
        end else begin
          dec_kind  = pll_pkg::KD_DEL;
          dec_head  = (used8 == 8'd1);
          // removing the head walks nowhere
          dec_steps = (used8 == 8'd1) ? '0 : CW'(used8 - 8'd2);
        end
      end
      pll_pkg::FN_DEL_POS: begin
        if (used8 == 8'd0) begin
          dec_st = pll_pkg::ST_EMPTY;
        end else if (pos8 == 8'd0 || pos8 > used8) begin
          dec_st = pll_pkg::ST_BADPOS;
        end else begin
          dec_kind  = pll_pkg::KD_DEL;
          dec_head  = (pos8 == 8'd1);
          dec_steps = (pos8 == 8'd1) ? '0 : CW'(pos8 - 8'd2);
        end
      end
      pll_pkg::FN_DUMP: begin
        if (used8 == 8'd0) begin
          dec_st = pll_pkg::ST_EMPTY;
        end else begin
          dec_kind  = pll_pkg::KD_DUMP;
          dec_steps = CW'(used8 - 8'd1);
        end
      end
      default: begin
        dec_st = pll_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pll_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    n_we       = 1'b0;
    n_waddr    = cur;
    n_wdata    = '0;
    n_raddr    = cur;
    aop        = '0;
    out_load   = 1'b0;
    unique case (state)
      pll_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (dec_kind == pll_pkg::KD_NONE) ? pll_pkg::S_EMIT : pll_pkg::S_LOAD;
        end
      end
      pll_pkg::S_LOAD: begin
        if (kind == pll_pkg::KD_INS && at_head) begin
          n_we       = 1'b1;
          n_waddr    = alloc_idx;
          n_wdata    = {val_q, head};
          aop.take   = 1'b1;
          state_next = pll_pkg::S_EMIT;
        end else if (kind == pll_pkg::KD_DUMP) begin
          state_next = pll_pkg::S_DUMP;
        end else begin
          state_next = pll_pkg::S_WALK;
        end
      end
      pll_pkg::S_WALK: begin
        if (steps != '0) begin
          n_raddr = rd_link;
        end else if (kind == pll_pkg::KD_INS) begin
          // new node takes the predecessor's successor
          n_we       = 1'b1;
          n_waddr    = nidx;
          n_wdata    = {val_q, rd_link};
          state_next = pll_pkg::S_INS_LINK;
        end else if (at_head) begin
          aop.give   = 1'b1;
          state_next = pll_pkg::S_EMIT;
        end else begin
          n_raddr    = rd_link;
          state_next = pll_pkg::S_DEL_WR;
        end
      end
      pll_pkg::S_INS_LINK: begin
        n_we       = 1'b1;
        n_wdata    = {pval, nidx};
        aop.take   = 1'b1;
        state_next = pll_pkg::S_EMIT;
      end
      pll_pkg::S_DEL_WR: begin
        // predecessor skips the removed node
        n_we       = 1'b1;
        n_wdata    = {pval, rd_link};
        aop.give   = 1'b1;
        state_next = pll_pkg::S_EMIT;
      end
      pll_pkg::S_DUMP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (steps != '0) begin
            n_raddr = rd_link;
          end else begin
            state_next = pll_pkg::S_IDLE;
          end
        end
      end
      pll_pkg::S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = pll_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pll_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pll_pkg::S_IDLE: begin
          if (accept) begin
            cur     <= head;
            steps   <= dec_steps;
            kind    <= dec_kind;
            at_head <= dec_head;
            res_st  <= dec_st;
            val_q   <= req.value;
          end
        end
        pll_pkg::S_LOAD: begin
          nidx <= alloc_idx;
          if (kind == pll_pkg::KD_INS && at_head) begin
            head <= alloc_idx;
            used <= used + CW'(1);
          end
        end
        pll_pkg::S_WALK: begin
          if (steps != '0) begin
            cur   <= rd_link;
            steps <= steps - CW'(1);
          end else if (kind == pll_pkg::KD_DEL && at_head) begin
            head <= rd_link;
            used <= used - CW'(1);
          end else begin
            pval  <= rd_val;
            plink <= rd_link;
          end
        end
        pll_pkg::S_INS_LINK: begin
          used <= used + CW'(1);
        end
        pll_pkg::S_DEL_WR: begin
          used <= used - CW'(1);
        end
        pll_pkg::S_DUMP: begin
          if (out_free && steps != '0) begin
            cur   <= rd_link;
            steps <= steps - CW'(1);
          end
        end
        pll_pkg::S_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cnt <= 7'(used);
      if (state == pll_pkg::S_DUMP) begin
        out_st   <= pll_pkg::ST_OK;
        out_el   <= rd_val;
        out_last <= (steps == '0);
      end else begin
        out_st   <= res_st;
        out_el   <= '0;
        out_last <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/pll_checker.sv
// Port-level checks for the positional linked list, bound to the top level.
module pll_checker #(
  parameter int CAPACITY = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         status,
  input logic signed [31:0] element,
  input logic [6:0]         entry_count,
  input logic               last
);

  // a held result keeps its element and last flag
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(element) && $stable(last))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_count <= 7'(CAPACITY))
    else $error("entry count above capacity");

  // error results are single and carry no element
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != pll_pkg::ST_OK |-> last && element == '0)
    else $error("error result malformed");

endmodule

bind positional_linked_list pll_checker #(
  .CAPACITY (CAPACITY)
) u_pll_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .element     (rsp.element),
  .entry_count (rsp.entry_count),
  .last        (rsp.last)
);
